>>> src/wcb_pkg.sv
package wcb_pkg;

	// Command codes of the input channel
	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_START = 2'd1,
		CMD_ADD   = 2'd2,
		CMD_END   = 2'd3
	} cmd_t;

	// Register indexes of the configuration port
	localparam logic REG_INV_W = 1'b0;
	localparam logic REG_INV_H = 1'b1;

	// Field and state widths
	localparam int unsigned POS_W   = 20;
	localparam int unsigned SUM_W   = 24;
	localparam int unsigned CNT_W   = 4;
	localparam int unsigned WGT_W   = 17;
	localparam int unsigned COEF_W  = 32;
	localparam int unsigned MULB_W  = POS_W + 1;
	localparam int unsigned PROD_W  = COEF_W + MULB_W;
	localparam int unsigned ACC_W   = 56;
	localparam int unsigned TERMS   = 5;

	// Fixed-point constants
	localparam logic [WGT_W-1:0]         ONE_Q16  = 17'd65536;
	localparam logic signed [POS_W-1:0]  HALF_Q16 = 20'sd32768;
	localparam logic signed [POS_W-1:0]  POS_MAX  = 20'sd524287;
	localparam logic [SUM_W-1:0]         SUM_MAX  = 24'hFFFFFF;
	localparam logic [CNT_W-1:0]         CNT_MAX  = 4'd15;
	localparam logic signed [ACC_W-1:0]  ROUND_HALF = 56'sd536870912;

	// Low-pass biquad coefficients, Q2.30
	localparam logic signed [COEF_W-1:0] CB0 = 32'sd1128968;
	localparam logic signed [COEF_W-1:0] CB1 = 32'sd2257936;
	localparam logic signed [COEF_W-1:0] CA1 = 32'sd2071430318;
	localparam logic signed [COEF_W-1:0] CA2 = -32'sd1002204367;

	// Coefficient for term k: x0, x1, x2, y0, y1
	function automatic logic signed [COEF_W-1:0] coef(input logic [2:0] k);
		logic signed [COEF_W-1:0] c;
		case (k)
			3'd0: c = CB0;
			3'd1: c = CB1;
			3'd2: c = CB0;
			3'd3: c = CA1;
			3'd4: c = CA2;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

>>> src/weighted_centroid_biquad_lowpass.sv
// Path to result valid: clear and start load the result directly, add normalises and
// weights the coordinates, end divides (when players active) and filters once per tick.
// One item in flight at a time; the next item is taken once the result is registered.
// Rate is set by the single shared 32x21 multiplier (five products per channel per
// tick) and the one-bit-per-cycle divider.
// arst_n clears slots, sums and count, loads 0.5 into filter history, 16 into both reciprocals.
module weighted_centroid_biquad_lowpass
	import wcb_pkg::*;
#(
	parameter int unsigned MAX_PLAYERS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// input channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              command,
	input  logic [15:0]             frame_dt,
	input  logic [2:0]              player_slot,
	input  logic [11:0]             player_x,
	input  logic [11:0]             player_y,
	input  logic                    player_killed,
	input  logic [3:0]              tick_count,
	// output channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [19:0]      filtered_x,
	output logic signed [19:0]      filtered_y,
	output logic [3:0]              active_count,
	output logic                    none_active
);

	localparam int unsigned SLOT_W = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;
	localparam int unsigned SEXT_W = SLOT_W + 3;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD_NX,
		S_ADD_WX,
		S_ADD_NY,
		S_ADD_WY,
		S_ADD_ACC,
		S_DIV,
		S_DIV_WB,
		S_F_SHIFT,
		S_F_MUL,
		S_F_LAST,
		S_F_WB,
		S_DONE
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [15:0] inv_w_q;
	logic [15:0] inv_h_q;

	// Slot table and frame state
	logic                    known_q  [MAX_PLAYERS];
	logic [WGT_W-1:0]        weight_tbl_q [MAX_PLAYERS];
	logic [15:0]             fade_q;
	logic [SUM_W-1:0]        sum_q    [2];
	logic [CNT_W-1:0]        active_q;
	logic signed [POS_W-1:0] ih_q     [2][3];
	logic signed [POS_W-1:0] oh_q     [2][2];

	// Per-item working registers
	logic [WGT_W-1:0]        weight_q;
	logic [11:0]             x_q;
	logic [11:0]             y_q;
	logic [3:0]              tick_q;
	logic [CNT_W-1:0]        rem_q    [2];
	logic [4:0]              cnt_q;
	logic [2:0]              k_q;
	logic                    ch_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [PROD_W-1:0] product_q;

	// Shared multiplier
	logic signed [COEF_W-1:0] mul_a;
	logic signed [MULB_W-1:0] mul_b;
	logic signed [PROD_W-1:0] mul_p;

	// Slot decode on the incoming item
	logic [SEXT_W-1:0] slot_ext;
	logic [SLOT_W-1:0] slot_idx;
	logic              slot_ok;
	logic [WGT_W-1:0]  faded_w;
	logic [WGT_W-1:0]  weight_d;
	logic [WGT_W-1:0]  fade_ext;

	// Datapath helpers
	logic [POS_W-1:0]        norm_sat;
	logic [POS_W-1:0]        term;
	logic [SUM_W:0]          sum_add;
	logic [SUM_W-1:0]        sum_next;
	logic signed [ACC_W-1:0] acc_sum;
	logic signed [ACC_W-1:0] acc_shr;
	logic signed [POS_W-1:0] y_new;
	logic signed [POS_W-1:0] hist_sel;
	logic [CNT_W:0]          trial   [2];
	logic                    ge      [2];
	logic                    cfg_wr;

	assign pready   = 1'b1;
	assign in_ready = (state_q == S_IDLE);
	assign cfg_wr   = psel && penable && pwrite;

	// Read back configuration
	always_comb begin
		case (paddr[2])
			REG_INV_W: prdata = {16'd0, inv_w_q};
			REG_INV_H: prdata = {16'd0, inv_h_q};
			default:   prdata = '0;
		endcase
	end

	// Decode the slot and work out the faded weight
	always_comb begin
		slot_ext = {{SLOT_W{1'b0}}, player_slot};
		slot_idx = slot_ext[SLOT_W-1:0];
		slot_ok  = slot_ext < SEXT_W'(MAX_PLAYERS);
		fade_ext = {1'b0, fade_q};
		faded_w  = (weight_tbl_q[slot_idx] > fade_ext) ?
			(weight_tbl_q[slot_idx] - fade_ext) : '0;
		if (known_q[slot_idx] && player_killed) begin
			weight_d = faded_w;
		end else begin
			weight_d = ONE_Q16;
		end
	end

	// Saturate a normalised coordinate and pick up a weighted term
	always_comb begin
		norm_sat = (product_q > PROD_W'(POS_MAX)) ? POS_MAX : product_q[POS_W-1:0];
		term     = product_q[POS_W+15:16];
		sum_add  = {1'b0, sum_q[ch_q]} + {{(SUM_W-POS_W+1){1'b0}}, term};
		sum_next = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
	end

	// Select the filter history term
	always_comb begin
		case (k_q)
			3'd0:    hist_sel = ih_q[ch_q][0];
			3'd1:    hist_sel = ih_q[ch_q][1];
			3'd2:    hist_sel = ih_q[ch_q][2];
			3'd3:    hist_sel = oh_q[ch_q][0];
			3'd4:    hist_sel = oh_q[ch_q][1];
			default: hist_sel = '0;
		endcase
	end

	// Multiplier operand selection
	always_comb begin
		case (state_q)
			S_ADD_NX: begin
				mul_a = {16'd0, inv_w_q};
				mul_b = {9'd0, x_q};
			end
			S_ADD_WX, S_ADD_WY: begin
				mul_a = {{(COEF_W-WGT_W){1'b0}}, weight_q};
				mul_b = {1'b0, norm_sat};
			end
			S_ADD_NY: begin
				mul_a = {16'd0, inv_h_q};
				mul_b = {9'd0, y_q};
			end
			S_F_MUL: begin
				mul_a = coef(k_q);
				mul_b = {hist_sel[POS_W-1], hist_sel};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Accumulate, round and saturate the filter output
	always_comb begin
		acc_sum = acc_q + {{(ACC_W-PROD_W){product_q[PROD_W-1]}}, product_q};
		acc_shr = acc_q >>> 30;
		if (acc_shr > ACC_W'(POS_MAX)) begin
			y_new = POS_MAX;
		end else if (acc_shr < -ACC_W'(POS_MAX) - 1) begin
			y_new = -POS_MAX - 1;
		end else begin
			y_new = acc_shr[POS_W-1:0];
		end
	end

	// One restoring division step per channel
	always_comb begin
		for (int c = 0; c < 2; c++) begin
			trial[c] = {rem_q[c], sum_q[c][SUM_W-1]};
			ge[c]    = trial[c] >= {1'b0, active_q};
		end
	end

	// Register the multiplier product
	always_ff @(posedge clk) begin
		product_q <= mul_p;
	end

	// Sequencer, state and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			inv_w_q  <= 16'd16;
			inv_h_q  <= 16'd16;
			for (int i = 0; i < MAX_PLAYERS; i++) begin
				known_q[i]      <= 1'b0;
				weight_tbl_q[i] <= ONE_Q16;
			end
			fade_q   <= '0;
			active_q <= '0;
			for (int c = 0; c < 2; c++) begin
				sum_q[c] <= '0;
				rem_q[c] <= '0;
				for (int j = 0; j < 3; j++) ih_q[c][j] <= HALF_Q16;
				for (int j = 0; j < 2; j++) oh_q[c][j] <= HALF_Q16;
			end
			weight_q     <= '0;
			x_q          <= '0;
			y_q          <= '0;
			tick_q       <= '0;
			cnt_q        <= '0;
			k_q          <= '0;
			ch_q         <= 1'b0;
			acc_q        <= '0;
			out_valid    <= 1'b0;
			filtered_x   <= '0;
			filtered_y   <= '0;
			active_count <= '0;
			none_active  <= 1'b0;
		end else begin
			// Configuration writes
			if (cfg_wr) begin
				case (paddr[2])
					REG_INV_W: inv_w_q <= pwdata[15:0];
					REG_INV_H: inv_h_q <= pwdata[15:0];
					default: ;
				endcase
			end

			// Drop the result once transferred, unless the done state reloads it
			if (out_valid && out_ready && state_q != S_DONE) begin
				out_valid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						x_q    <= player_x;
						y_q    <= player_y;
						tick_q <= tick_count;
						ch_q   <= 1'b0;
						case (cmd_t'(command))
							CMD_CLEAR: begin
								for (int i = 0; i < MAX_PLAYERS; i++) known_q[i] <= 1'b0;
								active_q <= '0;
								state_q  <= S_DONE;
							end
							CMD_START: begin
								fade_q   <= {2'b00, frame_dt[15:2]};
								active_q <= '0;
								sum_q[0] <= '0;
								sum_q[1] <= '0;
								state_q  <= S_DONE;
							end
							CMD_ADD: begin
								if (slot_ok) begin
									known_q[slot_idx] <= 1'b1;
									if (!known_q[slot_idx] || player_killed) begin
										weight_tbl_q[slot_idx] <= weight_d;
									end
									weight_q <= weight_d;
									state_q  <= (weight_d != '0) ? S_ADD_NX : S_DONE;
								end else begin
									state_q <= S_DONE;
								end
							end
							CMD_END: begin
								if (active_q == '0) begin
									sum_q[0] <= SUM_W'(HALF_Q16);
									sum_q[1] <= SUM_W'(HALF_Q16);
									state_q  <= (tick_count != '0) ? S_F_SHIFT : S_DONE;
								end else begin
									rem_q[0] <= '0;
									rem_q[1] <= '0;
									cnt_q    <= '0;
									state_q  <= S_DIV;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end

				// Add: normalise, weight and accumulate x then y
				S_ADD_NX:  state_q <= S_ADD_WX;
				S_ADD_WX: begin
					ch_q    <= 1'b0;
					state_q <= S_ADD_NY;
				end
				S_ADD_NY: begin
					sum_q[0] <= sum_next;
					ch_q     <= 1'b1;
					state_q  <= S_ADD_WY;
				end
				S_ADD_WY:  state_q <= S_ADD_ACC;
				S_ADD_ACC: begin
					sum_q[1] <= sum_next;
					if (active_q != CNT_MAX) begin
						active_q <= active_q + 1'b1;
					end
					state_q <= S_DONE;
				end

				// End: average by shifting the quotient into the sum registers
				S_DIV: begin
					for (int c = 0; c < 2; c++) begin
						rem_q[c] <= ge[c] ? (trial[c][CNT_W-1:0] - active_q) :
							trial[c][CNT_W-1:0];
						sum_q[c] <= {sum_q[c][SUM_W-2:0], ge[c]};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 5'(SUM_W - 1)) begin
						state_q <= S_DIV_WB;
					end
				end
				S_DIV_WB: begin
					for (int c = 0; c < 2; c++) begin
						if (sum_q[c] > SUM_W'(POS_MAX)) sum_q[c] <= SUM_W'(POS_MAX);
					end
					state_q <= (tick_q != '0) ? S_F_SHIFT : S_DONE;
				end

				// Filter tick: advance input history, then five products per channel
				S_F_SHIFT: begin
					for (int c = 0; c < 2; c++) begin
						ih_q[c][2] <= ih_q[c][1];
						ih_q[c][1] <= ih_q[c][0];
						ih_q[c][0] <= sum_q[c][POS_W-1:0];
					end
					ch_q    <= 1'b0;
					k_q     <= '0;
					state_q <= S_F_MUL;
				end
				S_F_MUL: begin
					acc_q <= (k_q == '0) ? ROUND_HALF : acc_sum;
					k_q   <= k_q + 1'b1;
					if (k_q == 3'(TERMS - 1)) begin
						state_q <= S_F_LAST;
					end
				end
				S_F_LAST: begin
					acc_q   <= acc_sum;
					state_q <= S_F_WB;
				end
				S_F_WB: begin
					oh_q[ch_q][1] <= oh_q[ch_q][0];
					oh_q[ch_q][0] <= y_new;
					k_q <= '0;
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= S_F_MUL;
					end else begin
						tick_q  <= tick_q - 1'b1;
						state_q <= (tick_q == 4'd1) ? S_DONE : S_F_SHIFT;
					end
				end

				// Hold until the output register is free, then load the result
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						filtered_x   <= oh_q[0][0];
						filtered_y   <= oh_q[1][0];
						active_count <= active_q;
						none_active  <= (active_q == '0);
						state_q      <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	// One item in flight: a transfer always takes the sequencer out of idle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in flight");

	// The divider only runs with a nonzero count
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> active_q != '0)
		else $error("division started with zero active players");

	// The reported flag agrees with the reported count
	a_none_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> none_active == (active_count == '0))
		else $error("none_active disagrees with active_count");

	// A result is loaded only from the done state
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside the done state");

endmodule

>>> bench/weighted_centroid_biquad_lowpass_tb.sv
`timescale 1ns / 1ps

module weighted_centroid_biquad_lowpass_tb;
	import wcb_pkg::*;

	localparam int NUM_SLOTS = 8;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLDOFF_CYCLES = 300;

	// Q2.30 low-pass taps and rounding for the smoothing filter
	localparam longint K_B0 = 64'sd1128968;
	localparam longint K_B1 = 64'sd2257936;
	localparam longint K_A1 = 64'sd2071430318;
	localparam longint K_A2 = -64'sd1002204367;
	localparam longint K_ROUND = 64'sd536870912;
	localparam longint Q_ONE = 65536;
	localparam longint Q_HALF = 32768;
	localparam longint P_MAX = 524287;
	localparam longint P_MIN = -524288;
	localparam longint ACC_MAX = 16777215;

	typedef struct {
		cmd_t        cmd;
		logic [15:0] dt;
		logic [2:0]  slot;
		logic [11:0] px;
		logic [11:0] py;
		logic        killed;
		logic [3:0]  ticks;
	} frame_cmd_t;

	typedef struct {
		logic signed [19:0] fx;
		logic signed [19:0] fy;
		logic [3:0]         cnt;
		logic               none;
	} point_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid, in_ready;
	logic [1:0] command;
	logic [15:0] frame_dt;
	logic [2:0] player_slot;
	logic [11:0] player_x, player_y;
	logic player_killed;
	logic [3:0] tick_count;
	logic out_valid, out_ready;
	logic signed [19:0] filtered_x, filtered_y;
	logic [3:0] active_count;
	logic none_active;

	// Predicted block state
	longint inv_w, inv_h;
	bit slot_seen [NUM_SLOTS];
	longint slot_wt [NUM_SLOTS];
	longint fade_amt;
	longint acc_x, acc_y;
	longint n_active;
	longint lp_in [3][2];
	longint lp_out [2][2];

	point_t expected_points [$];
	int mismatch_count = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	int hold_left = 0;
	int stall_left = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;

	weighted_centroid_biquad_lowpass dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .command(command),
		.frame_dt(frame_dt), .player_slot(player_slot), .player_x(player_x),
		.player_y(player_y), .player_killed(player_killed), .tick_count(tick_count),
		.out_valid(out_valid), .out_ready(out_ready), .filtered_x(filtered_x),
		.filtered_y(filtered_y), .active_count(active_count), .none_active(none_active)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [11:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 12'd0;
		if (r == 1) return 12'd4095;
		return 12'($urandom_range(0, 4095));
	endfunction

	// Command with random content in the fields it does not use
	function automatic frame_cmd_t blank_cmd(cmd_t c);
		frame_cmd_t it;
		it.cmd = c;
		it.dt = 16'($urandom);
		it.slot = 3'($urandom);
		it.px = 12'($urandom);
		it.py = 12'($urandom);
		it.killed = 1'($urandom);
		it.ticks = 4'($urandom);
		return it;
	endfunction

	function automatic longint scale_coord(logic [11:0] coord, longint inv);
		longint p;
		p = longint'(coord) * inv;
		return (p > P_MAX) ? P_MAX : p;
	endfunction

	function automatic longint clamp_pos(longint v);
		if (v > P_MAX) return P_MAX;
		if (v < P_MIN) return P_MIN;
		return v;
	endfunction

	task automatic reset_centroid_state();
		int i;
		inv_w = 16;
		inv_h = 16;
		for (i = 0; i < NUM_SLOTS; i++) begin
			slot_seen[i] = 1'b0;
			slot_wt[i] = Q_ONE;
		end
		n_active = 0;
		fade_amt = 0;
		acc_x = 0;
		acc_y = 0;
		for (i = 0; i < 3; i++) begin
			lp_in[i][0] = Q_HALF;
			lp_in[i][1] = Q_HALF;
		end
		for (i = 0; i < 2; i++) begin
			lp_out[i][0] = Q_HALF;
			lp_out[i][1] = Q_HALF;
		end
	endtask

	// Advance the predicted state by one command and report the smoothed point
	task automatic predict_centroid(input frame_cmd_t it, output point_t res);
		int i, c;
		longint w, term;
		case (it.cmd)
			CMD_CLEAR: begin
				for (i = 0; i < NUM_SLOTS; i++) begin
					slot_seen[i] = 1'b0;
					slot_wt[i] = Q_ONE;
				end
				n_active = 0;
			end
			CMD_START: begin
				fade_amt = longint'(it.dt) >> 2;
				n_active = 0;
				acc_x = 0;
				acc_y = 0;
			end
			CMD_ADD: begin
				w = Q_ONE;
				if (slot_seen[it.slot]) begin
					// dead player fades, saturating at zero
					if (it.killed) begin
						slot_wt[it.slot] = (slot_wt[it.slot] > fade_amt) ?
							slot_wt[it.slot] - fade_amt : 0;
						w = slot_wt[it.slot];
					end
				end else begin
					slot_seen[it.slot] = 1'b1;
					slot_wt[it.slot] = Q_ONE;
				end
				if (w > 0) begin
					term = (scale_coord(it.px, inv_w) * w) >> 16;
					acc_x = (acc_x + term > ACC_MAX) ? ACC_MAX : acc_x + term;
					term = (scale_coord(it.py, inv_h) * w) >> 16;
					acc_y = (acc_y + term > ACC_MAX) ? ACC_MAX : acc_y + term;
					if (n_active < 15) n_active++;
				end
			end
			CMD_END: begin
				if (n_active > 0) begin
					acc_x = acc_x / n_active;
					acc_y = acc_y / n_active;
					if (acc_x > P_MAX) acc_x = P_MAX;
					if (acc_y > P_MAX) acc_y = P_MAX;
				end else begin
					acc_x = Q_HALF;
					acc_y = Q_HALF;
				end
				// one biquad pass per elapsed tick
				repeat (it.ticks) begin
					for (c = 0; c < 2; c++) begin
						lp_in[2][c] = lp_in[1][c];
						lp_in[1][c] = lp_in[0][c];
						lp_in[0][c] = (c == 0) ? acc_x : acc_y;
						term = K_B0 * lp_in[0][c] + K_B1 * lp_in[1][c] + K_B0 * lp_in[2][c]
							+ K_A1 * lp_out[0][c] + K_A2 * lp_out[1][c];
						lp_out[1][c] = lp_out[0][c];
						lp_out[0][c] = clamp_pos((term + K_ROUND) >>> 30);
					end
				end
			end
		endcase
		res.fx = lp_out[0][0][19:0];
		res.fy = lp_out[0][1][19:0];
		res.cnt = n_active[3:0];
		res.none = (n_active == 0);
	endtask

	// Offer one command, hold until transfer, then idle a random gap if enabled
	task automatic send_cmd(input frame_cmd_t it);
		point_t res;
		command <= it.cmd;
		frame_dt <= it.dt;
		player_slot <= it.slot;
		player_x <= it.px;
		player_y <= it.py;
		player_killed <= it.killed;
		tick_count <= it.ticks;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_centroid(it, res);
		expected_points.push_back(res);
		items_sent++;
		if (tx_idle_on && pick_gap() > 0) begin
			in_valid <= 1'b0;
			repeat (pick_gap() + 1) @(posedge clk);
		end
	endtask

	task automatic send_start(input logic [15:0] dt);
		frame_cmd_t it;
		it = blank_cmd(CMD_START);
		it.dt = dt;
		send_cmd(it);
	endtask

	task automatic send_add(input logic [2:0] slot, input logic [11:0] x,
			input logic [11:0] y, input logic killed);
		frame_cmd_t it;
		it = blank_cmd(CMD_ADD);
		it.slot = slot;
		it.px = x;
		it.py = y;
		it.killed = killed;
		send_cmd(it);
	endtask

	task automatic send_end(input logic [3:0] ticks);
		frame_cmd_t it;
		it = blank_cmd(CMD_END);
		it.ticks = ticks;
		send_cmd(it);
	endtask

	// Drop valid and wait for every pending result
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_points.size() != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [15:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_INV_W) inv_w = val;
		else inv_h = val;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apb_check(input logic idx);
		longint want;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		want = (idx == REG_INV_W) ? inv_w : inv_h;
		if (prdata !== 32'(want)) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("register %0d read: expected %0d, got %0d", idx, want, prdata);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Reconfigure the arena only with the pipeline empty
	task automatic set_arena(input logic [15:0] w, input logic [15:0] h);
		wait_drained();
		repeat (4) @(posedge clk);
		apb_write(REG_INV_W, w);
		apb_write(REG_INV_H, h);
		apb_check(REG_INV_W);
		apb_check(REG_INV_H);
	endtask

	task automatic test_reset_values();
		apb_check(REG_INV_W);
		apb_check(REG_INV_H);
	endtask

	// Empty frames, new and known slots, fading to zero, repeated end, zero ticks
	task automatic test_directed_frames();
		send_end(4'd0);
		send_end(4'd2);
		send_cmd(blank_cmd(CMD_CLEAR));
		send_start(16'hFFFF);
		send_add(3'd0, 12'd0, 12'd0, 1'b0);
		send_add(3'd7, 12'd4095, 12'd4095, 1'b1);
		send_add(3'd0, 12'd1000, 12'd3000, 1'b1);
		send_add(3'd3, 12'd4095, 12'd0, 1'b0);
		send_end(4'd15);
		send_end(4'd1);
		send_start(16'hFFFF);
		repeat (5) send_add(3'd0, 12'd2048, 12'd4095, 1'b1);
		send_add(3'd0, 12'd4095, 12'd17, 1'b0);
		send_add(3'd0, 12'd4095, 12'd4095, 1'b1);
		send_end(4'd3);
		send_cmd(blank_cmd(CMD_CLEAR));
		send_add(3'd0, 12'd100, 12'd100, 1'b1);
		send_start(16'h0000);
		send_add(3'd7, 12'd4095, 12'd4095, 1'b1);
		send_end(4'd15);
	endtask

	// Overflow the count and the sums, push the filter into its upper clamp
	task automatic test_saturation();
		set_arena(16'hFFFF, 16'hFFFF);
		send_cmd(blank_cmd(CMD_CLEAR));
		send_start(16'($urandom));
		repeat (34) send_add(3'($urandom), 12'd4095, 12'd4095, 1'b0);
		repeat (3) send_end(4'd15);
		set_arena(16'd0, 16'd0);
		send_start(16'($urandom));
		send_add(3'd2, 12'd4095, 12'd4095, 1'b0);
		send_end(4'd15);
	endtask

	// Receiver holds off while the sender keeps offering back to back
	task automatic test_backpressure();
		set_arena(16'd16, 16'd16);
		tx_idle_on = 1'b0;
		hold_left = HOLDOFF_CYCLES;
		send_start(16'h4000);
		repeat (8) send_add(3'($urandom), rand_coord(), rand_coord(), 1'($urandom));
		send_end(4'd2);
		send_cmd(blank_cmd(CMD_CLEAR));
		tx_idle_on = 1'b1;
	endtask

	// Sender stops until all results are in, then resumes
	task automatic test_drain_pause();
		send_start(16'($urandom));
		send_add(3'd1, rand_coord(), rand_coord(), 1'b0);
		wait_drained();
		send_add(3'd4, rand_coord(), rand_coord(), 1'b1);
		send_end(4'd1);
	endtask

	// Mostly well-formed frames with random content, plus stray commands
	task automatic test_random_frames(input int n_items, input bit idling);
		int goal, r, n_add;
		logic [15:0] dt;
		logic [3:0] ticks;
		goal = items_sent + n_items;
		tx_idle_on = idling;
		rx_idle_on = idling;
		while (items_sent < goal) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				if ($urandom_range(0, 9) == 0) send_cmd(blank_cmd(CMD_CLEAR));
				r = $urandom_range(0, 9);
				dt = (r < 2) ? 16'hFFFF : (r == 2) ? 16'h0000 : 16'($urandom);
				send_start(dt);
				n_add = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 20)
					: $urandom_range(0, 10);
				repeat (n_add)
					send_add(3'($urandom), rand_coord(), rand_coord(),
						$urandom_range(0, 99) < 35);
				r = $urandom_range(0, 9);
				ticks = (r < 7) ? 4'($urandom_range(0, 3)) :
					(r < 9) ? 4'($urandom_range(4, 8)) : 4'($urandom_range(9, 15));
				send_end(ticks);
			end else if (r < 86) begin
				send_cmd(blank_cmd(CMD_CLEAR));
			end else if (r < 91) begin
				send_end(4'($urandom_range(0, 4)));
			end else if (r < 95) begin
				send_add(3'($urandom), rand_coord(), rand_coord(), 1'($urandom));
			end else if (r < 98) begin
				send_start(16'($urandom));
			end else begin
				wait_drained();
			end
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Receiver: long hold-off on request, else random stalls when enabled
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest prediction
	always @(posedge clk) begin
		point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: x=%0d y=%0d cnt=%0d none=%0d",
						filtered_x, filtered_y, active_count, none_active);
			end else begin
				want = expected_points.pop_front();
				if (filtered_x !== want.fx || filtered_y !== want.fy ||
						active_count !== want.cnt || none_active !== want.none) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected x=%0d y=%0d cnt=%0d none=%0d, got x=%0d y=%0d cnt=%0d none=%0d",
							want.fx, want.fy, want.cnt, want.none,
							filtered_x, filtered_y, active_count, none_active);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		command = CMD_CLEAR;
		frame_dt = '0;
		player_slot = '0;
		player_x = '0;
		player_y = '0;
		player_killed = 1'b0;
		tick_count = '0;
		out_ready = 1'b0;
		reset_centroid_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_directed_frames();
		test_saturation();
		test_backpressure();
		test_drain_pause();
		set_arena(16'd16, 16'd16);
		test_random_frames(240, 1'b1);
		set_arena(16'd0, 16'hFFFF);
		test_random_frames(240, 1'b1);
		set_arena(16'hFFFF, 16'd0);
		test_random_frames(240, 1'b0);
		set_arena(16'($urandom), 16'($urandom));
		test_random_frames(240, 1'b1);
		set_arena(16'($urandom_range(1, 64)), 16'($urandom_range(1, 64)));
		test_random_frames(240, 1'b1);
		set_arena(16'($urandom), 16'($urandom_range(1, 64)));
		test_random_frames(240, 1'b0);

		// Drain, then allow the longest end-frame latency to pass
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_points.size() != 0) begin
			mismatch_count++;
			$display("%0d results never arrived", expected_points.size());
		end
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
